[hdl/wris_pkg.sv]
// shared types and constants for the weighted random index sampler
package wris_pkg;

  localparam int NumSlots   = 16;
  localparam int SlotBits   = 4;
  localparam int WeightBits = 16;
  localparam int CountBits  = 5;
  localparam int SumBits    = 20;
  localparam int RotA       = 24;
  localparam int ShiftB     = 16;
  localparam int RotC       = 37;
  localparam logic [30:0] Scale = 31'h7fffffff;

  localparam logic [1:0] OpWrite  = 2'd0;
  localparam logic [1:0] OpDraw   = 2'd1;
  localparam logic [1:0] OpReseed = 2'd2;

  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatZeroSum   = 2'd1;
  localparam logic [1:0] StatZeroCount = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic write_weight;
    logic reseed;
    logic advance;
    logic mod_start;    // load 64-bit remainder loop (64 steps)
    logic mod_step;
    logic r_load;       // fold word mod 2^31-1 into r
    logic sum_clear;
    logic sum_step;     // add weight at walk pointer
    logic thr_start;    // start threshold division
    logic thr_step;
    logic walk_step;    // compare r with threshold, move pointer
    logic ptr_clear;
    logic load_out;
  } wris_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mod_done;
    logic thr_done;
    logic sum_zero;
    logic ptr_last;     // pointer at count-1
    logic hit;          // r below threshold
  } wris_stat_t;

endpackage

[hdl/wris_datapath.sv]
// generator, weight table, remainder and threshold units, walk registers
module wris_datapath (
  input  logic                         clk_i,
  input  wris_pkg::wris_cmd_t          cmd_i,
  output wris_pkg::wris_stat_t         stat_o,
  input  logic                         rst_ni,
  input  logic [63:0]                  seed_a_i,
  input  logic [63:0]                  seed_b_i,
  input  logic [wris_pkg::SlotBits-1:0]   weight_index_i,
  input  logic [wris_pkg::WeightBits-1:0] weight_value_i,
  input  logic [wris_pkg::CountBits-1:0]  choice_count_i,
  input  logic                         weighted_mode_i,
  output logic [wris_pkg::SlotBits-1:0] chosen_index_o,
  output logic [63:0]                  random_word_o,
  output logic [1:0]                   status_o
);
  import wris_pkg::*;

  logic [63:0] gen_a_q, gen_b_q, word_q;
  logic [WeightBits-1:0] table_q [NumSlots];
  logic [CountBits-1:0] count_q;
  logic mode_q;
  logic [SumBits-1:0] sum_q;
  logic [SlotBits-1:0] ptr_q;
  // shared restoring division: rem over a 64-bit dividend, one bit a step
  logic [63:0] dvd_q;
  logic [31:0] rem_q;
  logic [31:0] div_q;
  logic [63:0] quo_q;
  logic [6:0] cnt_q;
  logic [30:0] r_q;
  logic [63:0] b_x;
  logic [32:0] trial;
  logic [SlotBits-1:0] cnt_m1;
  // word mod 2^31-1 by folding 31-bit chunks, since 2^31 is 1 modulo it
  logic [32:0] fold_s1;
  logic [31:0] fold_s2;
  logic [30:0] r_fold;

  assign b_x = gen_b_q ^ gen_a_q;
  assign trial = {rem_q, dvd_q[63]} - {1'b0, div_q};
  assign cnt_m1 = SlotBits'(count_q - CountBits'(1));

  assign fold_s1 = {2'b0, word_q[30:0]} + {2'b0, word_q[61:31]} + {31'd0, word_q[63:62]};
  assign fold_s2 = {1'b0, fold_s1[30:0]} + {30'd0, fold_s1[32:31]};
  assign r_fold  = (fold_s2 >= {1'b0, Scale}) ? 31'(fold_s2 - {1'b0, Scale})
                                              : fold_s2[30:0];

  // generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_a_q <= 64'd1;
      gen_b_q <= 64'd0;
    end else if (cmd_i.reseed) begin
      gen_a_q <= seed_a_i;
      gen_b_q <= seed_b_i;
    end else if (cmd_i.advance) begin
      gen_a_q <= {gen_a_q[63-RotA:0], gen_a_q[63:64-RotA]} ^ b_x ^ (b_x << ShiftB);
      gen_b_q <= {b_x[63-RotC:0], b_x[63:64-RotC]};
    end
  end

  // weight table, undefined until written
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_weight) table_q[weight_index_i] <= weight_value_i;
  end

  // draw registers and walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      word_q  <= gen_a_q + gen_b_q;
      count_q <= (choice_count_i > CountBits'(NumSlots)) ? CountBits'(NumSlots)
                                                         : choice_count_i;
      mode_q  <= weighted_mode_i;
    end
    if (cmd_i.ptr_clear) ptr_q <= '0;
    if (cmd_i.sum_clear) sum_q <= '0;
    if (cmd_i.sum_step) begin
      sum_q <= sum_q + SumBits'(table_q[ptr_q]);
      ptr_q <= ptr_q + SlotBits'(1);
    end
    if (cmd_i.mod_start) begin
      dvd_q <= word_q;
      rem_q <= '0;
      div_q <= 32'(count_q);
      cnt_q <= '0;
    end else if (cmd_i.thr_start) begin
      dvd_q <= {17'd0, table_q[ptr_q], 31'd0} - {48'd0, table_q[ptr_q]};
      rem_q <= '0;
      div_q <= 32'(sum_q);
      cnt_q <= '0;
    end else if (cmd_i.mod_step || cmd_i.thr_step) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], ~trial[32]};
      rem_q <= trial[32] ? {rem_q[30:0], dvd_q[63]} : trial[31:0];
      cnt_q <= cnt_q + 7'd1;
    end
    if (cmd_i.r_load) r_q <= r_fold;
    if (cmd_i.walk_step && !stat_o.hit && !stat_o.ptr_last) begin
      r_q   <= r_q - quo_q[30:0];
      ptr_q <= ptr_q + SlotBits'(1);
    end
    if (cmd_i.load_out) begin
      random_word_o <= word_q;
      if (count_q == '0) begin
        status_o <= StatZeroCount; chosen_index_o <= '0;
      end else if (!mode_q) begin
        status_o <= StatOk; chosen_index_o <= rem_q[SlotBits-1:0];
      end else if (sum_q == '0) begin
        status_o <= StatZeroSum; chosen_index_o <= '0;
      end else begin
        status_o <= StatOk; chosen_index_o <= ptr_q;
      end
    end
  end

  assign stat_o.mod_done = (cnt_q == 7'd64);
  assign stat_o.thr_done = (cnt_q == 7'd64);
  assign stat_o.sum_zero = (sum_q == '0);
  assign stat_o.ptr_last = (ptr_q == cnt_m1);
  assign stat_o.hit      = ({1'b0, r_q} < quo_q[31:0]);
endmodule

[hdl/wris_ctrl.sv]
// sequencer for one item: write, reseed, or draw with modulo and walk
module wris_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [wris_pkg::CountBits-1:0] choice_count_i,
  input  logic                 weighted_mode_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wris_pkg::wris_cmd_t  cmd_o,
  input  wris_pkg::wris_stat_t stat_i
);
  import wris_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_SUMCHK, S_MODLD, S_MOD, S_THRLD, S_THR, S_WALK, S_OUT
  } state_e;

  state_e state_q;
  logic   weighted_q;
  logic   accept;
  logic [CountBits-1:0] sum_cnt_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_o;

  // command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.write_weight = accept && op_i == OpWrite;
    cmd_o.reseed       = accept && op_i == OpReseed;
    cmd_o.advance      = accept && op_i == OpDraw;
    cmd_o.sum_clear    = accept && op_i == OpDraw;
    cmd_o.ptr_clear    = (accept && op_i == OpDraw) || state_q == S_SUMCHK;
    cmd_o.sum_step     = state_q == S_SUM && sum_cnt_q != '0;
    cmd_o.mod_start    = state_q == S_MODLD && !weighted_q;
    cmd_o.r_load       = state_q == S_MODLD && weighted_q;
    cmd_o.mod_step     = state_q == S_MOD && !stat_i.mod_done;
    cmd_o.thr_start    = state_q == S_THRLD;
    cmd_o.thr_step     = state_q == S_THR && !stat_i.thr_done;
    cmd_o.walk_step    = state_q == S_WALK;
    cmd_o.load_out     = state_q == S_OUT;
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      weighted_q  <= 1'b0;
      sum_cnt_q   <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && op_i == OpDraw) begin
            weighted_q <= weighted_mode_i;
            sum_cnt_q  <= (choice_count_i > CountBits'(NumSlots)) ?
                          CountBits'(NumSlots) : choice_count_i;
            state_q    <= (choice_count_i == '0) ? S_OUT :
                          (weighted_mode_i ? S_SUM : S_MODLD);
          end
        end
        S_SUM: begin
          if (sum_cnt_q == '0) state_q <= S_SUMCHK;
          else sum_cnt_q <= sum_cnt_q - CountBits'(1);
        end
        S_SUMCHK: state_q <= stat_i.sum_zero ? S_OUT : S_MODLD;
        S_MODLD:  state_q <= weighted_q ? S_THRLD : S_MOD;
        S_MOD:    if (stat_i.mod_done) state_q <= S_OUT;
        S_THRLD:  state_q <= S_THR;
        S_THR:    if (stat_i.thr_done) state_q <= S_WALK;
        S_WALK:   state_q <= (stat_i.hit || stat_i.ptr_last) ? S_OUT : S_THRLD;
        S_OUT: begin
          out_valid_o <= 1'b1;
          state_q     <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/weighted_random_index_sampler.sv]
// top level: xoroshiro128+ driven uniform or weighted index sampler
// a write or reseed acts when taken; a uniform draw runs a remainder division;
// a weighted draw sums n weights, then divides and walks per slot up to pick k
// the shared bit-serial divider (64 steps per division) sets the rate
// one item at a time; the next item is taken once the result beat has left
// rst_ni clears the generator to (1, 0), seeds to (1, 0), and all control
module weighted_random_index_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  weight_index_i,
  input  logic [15:0] weight_value_i,
  input  logic [4:0]  choice_count_i,
  input  logic        weighted_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  chosen_index_o,
  output logic [63:0] random_word_o,
  output logic [1:0]  status_o
);
  import wris_pkg::*;

  logic [63:0] seed_a_q, seed_b_q;
  wris_cmd_t  cmd;
  wris_stat_t stat;

  // seed registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_a_q <= 64'd1;
      seed_b_q <= 64'd0;
    end else if (cfg_we_i) begin
      if (cfg_index_i) seed_b_q <= cfg_data_i;
      else seed_a_q <= cfg_data_i;
    end
  end

  wris_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .choice_count_i,
    .weighted_mode_i, .out_valid_o, .out_ready_i, .cmd_o(cmd), .stat_i(stat)
  );

  wris_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .seed_a_i(seed_a_q),
    .seed_b_i(seed_b_q), .weight_index_i, .weight_value_i, .choice_count_i,
    .weighted_mode_i, .chosen_index_o, .random_word_o, .status_o
  );
endmodule

[hdl/wris_checker.sv]
// port-level checks for the sampler, bound to the top level
module wris_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] op_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] chosen_index_o,
  input logic [1:0] status_o
);
  import wris_pkg::*;

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chosen_index_o))
    else $error("result changed while stalled");

  // status never takes the unused code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3) else $error("bad status");

  // error status gives index zero
  a_err_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatOk |-> chosen_index_o == '0)
    else $error("nonzero index on error");

  // no item taken while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken with result pending");

  // a non-draw item never makes a result next cycle
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i != OpDraw |=> !out_valid_o)
    else $error("result from non-draw item");
endmodule

bind weighted_random_index_sampler wris_checker u_wris_checker (.*);

[tb/tb_weighted_random_index_sampler.sv]
// self-checking testbench for the weighted random index sampler
`timescale 1ns / 100ps

module tb_weighted_random_index_sampler;
  import wris_pkg::*;

  localparam logic [1:0] OpNop = 2'd3;
  localparam logic CfgSeedA = 1'b0;
  localparam logic CfgSeedB = 1'b1;
  localparam int CycleLimit = 10000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [15:0] wval;
    logic [4:0]  count;
    logic        weighted;
  } item_t;

  typedef struct packed {
    logic [3:0]  pick;
    logic [63:0] word;
    logic [1:0]  stat;
  } draw_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [3:0]  weight_index_i = '0;
  logic [15:0] weight_value_i = '0;
  logic [4:0]  choice_count_i = '0;
  logic        weighted_mode_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  chosen_index_o;
  logic [63:0] random_word_o;
  logic [1:0]  status_o;

  weighted_random_index_sampler u_top (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [63:0] seed_a = 64'd1, seed_b = 64'd0, gen_a = 64'd1, gen_b = 64'd0;
  logic [15:0] weights [NumSlots];
  bit          written [NumSlots];

  item_t pending_items [$];
  draw_t expected_draws [$];
  int    mismatches = 0;
  int    cycles = 0;
  int    hold_off = 0;
  bit    sender_paused = 1'b0;
  int    burst_left = 0, gap_left = 0;
  logic  in_ready_o_q = 1'b0;

  function automatic logic [63:0] rotl(logic [63:0] v, int n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // predictor for one item: table write, reseed, or xoroshiro128+ step plus index selection
  function automatic void predict_draw(item_t it);
    logic [63:0] a, b, word, r, thr;
    logic [4:0]  cnt;
    logic [19:0] total;
    draw_t d;
    if (it.op == OpWrite) begin
      weights[it.slot] = it.wval;
      written[it.slot] = 1'b1;
      return;
    end
    if (it.op == OpReseed) begin
      gen_a = seed_a;
      gen_b = seed_b;
      return;
    end
    if (it.op != OpDraw) return;
    a = gen_a;
    b = gen_b;
    word = a + b;
    b ^= a;
    gen_a = rotl(a, RotA) ^ b ^ (b << ShiftB);
    gen_b = rotl(b, RotC);
    cnt = (it.count > NumSlots) ? 5'(NumSlots) : it.count;
    d.pick = '0;
    d.word = word;
    d.stat = StatOk;
    if (cnt == 0) d.stat = StatZeroCount;
    else if (!it.weighted) d.pick = 4'(word % 64'(cnt));
    else begin
      total = '0;
      for (int i = 0; i < cnt; i++) total += 20'(weights[i]);
      if (total == 0) d.stat = StatZeroSum;
      else begin
        r = word % 64'(Scale);
        for (int p = 0; ; p++) begin
          thr = (64'(weights[p]) * 64'(Scale)) / 64'(total);
          d.pick = 4'(p);
          if (r < thr || p + 1 >= cnt) break;
          r -= thr;
        end
      end
    end
    expected_draws.push_back(d);
  endfunction

  // build one item; weighted draws only over written slots
  function automatic item_t make_item(logic [1:0] op, int cnt, bit wm);
    item_t it;
    it.op = op;
    it.slot = 4'($urandom_range(0, 15));
    it.wval = 16'($urandom);
    it.count = 5'(cnt);
    it.weighted = wm;
    if (op == OpDraw && wm) begin
      int lim = 0;
      while (lim < 16 && written[lim]) lim++;
      if (cnt > lim || (cnt > 16 && lim < 16)) it.count = 5'(lim);
    end
    return it;
  endfunction

  // queue an item and mark writes so later draw shaping sees them
  task automatic push(item_t it);
    if (it.op == OpWrite) written[it.slot] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_draws.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgSeedA) seed_a = val; else seed_b = val;
  endtask

  // sender: bursts and gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && !in_ready_o_q)) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (!sender_paused && pending_items.size() != 0) begin
          item_t it;
          it = pending_items.pop_front();
          in_valid_i <= 1'b1;
          op_i <= it.op;
          weight_index_i <= it.slot;
          weight_value_i <= it.wval;
          choice_count_i <= it.count;
          weighted_mode_i <= it.weighted;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
          end
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // acceptance seen at the rising edge
  always @(posedge clk_i) begin
    in_ready_o_q <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      predict_draw(item_t'{op_i, weight_index_i, weight_value_i, choice_count_i,
                           weighted_mode_i});
    end
  end

  // receiver stall pattern, with long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else out_ready_i <= ($urandom_range(0, 3) != 0) || (cycles % 4000 > 3000);
  end

  // result monitor
  always @(posedge clk_i) begin
    draw_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: idx %0d word %h status %0d",
                                       chosen_index_o, random_word_o, status_o);
      end else begin
        e = expected_draws.pop_front();
        if (e.pick !== chosen_index_o || e.word !== random_word_o || e.stat !== status_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d word %h st %0d, got idx %0d word %h st %0d",
                     e.pick, e.word, e.stat, chosen_index_o, random_word_o, status_o);
        end
      end
    end
    if (cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      weights[i] = '0;
      written[i] = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: draws from reset state, zero count, uniform, nop, slot writes
    push(make_item(OpDraw, 0, 1'b0));
    push(make_item(OpDraw, 1, 1'b0));
    push(make_item(OpDraw, 16, 1'b0));
    push(make_item(OpDraw, 31, 1'b0));
    push(make_item(OpNop, 3, 1'b1));
    for (int i = 0; i < 16; i++) begin
      item_t it;
      it = make_item(OpWrite, 0, 1'b0);
      it.slot = 4'(i);
      it.wval = (i < 4) ? 16'd0 : (i == 15 ? 16'hffff : 16'(i * 1000));
      push(it);
    end
    push(make_item(OpDraw, 3, 1'b1));   // zero weight sum
    push(make_item(OpDraw, 16, 1'b1));
    push(make_item(OpDraw, 20, 1'b1));  // count clipped to 16 by make_item
    push(make_item(OpReseed, 0, 1'b0));
    push(make_item(OpDraw, 16, 1'b0));
    wait_idle();

    // random phases with several seed settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_cfg(CfgSeedA, '1); write_cfg(CfgSeedB, '1); end
        1: begin write_cfg(CfgSeedA, '0); write_cfg(CfgSeedB, 64'd1); end
        default: begin
          write_cfg(CfgSeedA, {$urandom, $urandom});
          write_cfg(CfgSeedB, {$urandom, $urandom});
        end
      endcase
      push(make_item(OpReseed, 0, 1'b0));
      for (int n = 0; n < 370; n++) begin
        int k;
        item_t it;
        k = $urandom_range(0, 99);
        if (k < 25) begin
          it = make_item(OpWrite, 0, 1'b0);
          if ($urandom_range(0, 4) == 0) it.wval = $urandom_range(0, 1) ? 16'hffff : 16'd0;
        end else if (k < 90)
          it = make_item(OpDraw, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                                            : $urandom_range(1, 16),
                         $urandom_range(0, 1));
        else if (k < 96) it = make_item(OpReseed, 0, 1'b0);
        else begin
          it = make_item(OpNop, $urandom_range(0, 31), 1'b0);
          it.op = OpNop;
        end
        push(it);
      end
      if (ph == 1) hold_off = 3000;
      if (ph == 3) begin
        while (pending_items.size() > 100) @(posedge clk_i);
        sender_paused = 1'b1;
        while (in_valid_i || expected_draws.size() != 0) @(posedge clk_i);
        sender_paused = 1'b0;
      end
      wait_idle();
    end

    repeat (1200) @(posedge clk_i);
    if (mismatches == 0 && expected_draws.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/wris_pkg.sv
hdl/wris_datapath.sv
hdl/wris_ctrl.sv
hdl/weighted_random_index_sampler.sv
hdl/wris_checker.sv
tb/tb_weighted_random_index_sampler.sv
